@@ rtl/core/sv39_page_table_mapper_assert.svh @@
// assertion macros shared by the page table mapper rtl
// expects clk_i and rst_ni in the scope of the including module
`ifndef SV39_PAGE_TABLE_MAPPER_ASSERT_SVH
`define SV39_PAGE_TABLE_MAPPER_ASSERT_SVH

// same-cycle implication
`define SV39PTM_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SV39PTM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/sv39ptm_pkg.sv @@
// shared types and constants for the sv39 page table mapper
// no dependencies
`default_nettype none

package sv39ptm_pkg;

  localparam int unsigned SPTM_STORE_PAGES  = 64;
  localparam int unsigned SPTM_TABLE_LEVELS = 3;

  localparam int unsigned PAGE_W    = 44;
  localparam int unsigned VA_W      = 39;
  localparam int unsigned PA_W      = 56;
  localparam int unsigned FLAGS_W   = 10;
  localparam int unsigned WIDX_W    = 15;
  localparam int unsigned WORD_W    = 64;
  localparam int unsigned PPN_W     = 54;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [PAGE_W-1:0] RST_FREE_START = 44'd0;
  localparam logic [PAGE_W-1:0] RST_FREE_END   = 44'd64;

  localparam logic [CFG_IDX_W-1:0] CFG_FREE_START = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FREE_END   = 1'd1;

  typedef enum logic [1:0] {
    CMD_MAP   = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_VA_UNALIGNED = 3'd1,
    ST_PA_UNALIGNED = 3'd2,
    ST_NO_MEM       = 3'd3,
    ST_OUTSIDE      = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_ROOT,
    DP_RD_ENT,
    DP_TAKE_ENT,
    DP_GRAB,
    DP_ZERO,
    DP_LINK,
    DP_SLOT,
    DP_LEAF,
    DP_RD_WORD
  } dp_op_e;

  typedef struct packed {
    dp_op_e  op;
    logic    fin;
    status_e fin_st;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       va_unal;
    logic       pa_unal;
    logic       root_ok;
    status_e    grab_st;
    logic       widx_ok;
    logic       ent_valid;
    logic       next_ok;
    logic       level_last;
    logic       zero_last;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/sv39ptm_dp.sv @@
// datapath: table store, allocation pointer, walk registers and result word
// depends on sv39ptm_pkg
`default_nettype none

module sv39ptm_dp import sv39ptm_pkg::*; #(
  parameter int unsigned STORE_PAGES  = SPTM_STORE_PAGES,
  parameter int unsigned TABLE_LEVELS = SPTM_TABLE_LEVELS
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [PAGE_W-1:0]    cfg_data_i,
  input  wire logic [1:0]           cmd_i,
  input  wire logic [PAGE_W-1:0]    root_page_i,
  input  wire logic [VA_W-1:0]      virt_addr_i,
  input  wire logic [PA_W-1:0]      phys_addr_i,
  input  wire logic [FLAGS_W-1:0]   pte_flags_i,
  input  wire logic [WIDX_W-1:0]    word_index_i,
  input  wire dp_cmd_t              dp_cmd_i,
  output dp_stat_t                  dp_stat_o,
  output logic [2:0]                status_o,
  output logic [PAGE_W-1:0]         new_page_o,
  output logic [WIDX_W-1:0]         leaf_word_o,
  output logic [WORD_W-1:0]         data_word_o,
  output logic [1:0]                tables_added_o
);

  localparam int unsigned PW          = $clog2(STORE_PAGES);
  localparam int unsigned AW          = PW + 9;
  localparam int unsigned STORE_WORDS = STORE_PAGES * 512;
  localparam int unsigned LVW         = $clog2(TABLE_LEVELS);

  typedef struct packed {
    logic          ok;
    logic [PW-1:0] slot;
  } slot_t;

  function automatic slot_t slot_of(input logic [PPN_W-1:0] page,
                                    input logic [PAGE_W-1:0] base);
    logic [PPN_W-1:0] base_x;
    logic [PPN_W-1:0] diff;
    slot_t            r;
    base_x = PPN_W'(base);
    diff   = page - base_x;
    r.ok   = (page >= base_x) && (diff < PPN_W'(STORE_PAGES));
    r.slot = diff[PW-1:0];
    return r;
  endfunction

  // latched command word
  logic [1:0]         cmd_q;
  logic [PAGE_W-1:0]  root_q;
  logic [VA_W-1:0]    va_q;
  logic [PA_W-1:0]    pa_q;
  logic [FLAGS_W-1:0] flags_q;
  logic [WIDX_W-1:0]  widx_q;

  // allocator
  logic [PAGE_W-1:0]  start_q;
  logic [PAGE_W-1:0]  end_q;
  logic [PAGE_W-1:0]  next_free_q;

  // walk state
  logic [PW-1:0]      slot_q;
  logic [LVW-1:0]     level_q;
  logic [PPN_W-1:0]   next_pg_q;
  logic [PW-1:0]      zslot_q;
  logic [8:0]         zcnt_q;
  logic [1:0]         added_q;
  logic [WORD_W-1:0]  rdata_q;

  // result word
  status_e            status_q;
  logic [PAGE_W-1:0]  new_page_q;
  logic [WIDX_W-1:0]  leaf_q;
  logic [WORD_W-1:0]  data_q;
  logic [1:0]         added_out_q;

  logic [WORD_W-1:0]  store_mem [STORE_WORDS];

  slot_t              root_sl;
  slot_t              free_sl;
  slot_t              next_sl;
  status_e            grab_st;
  logic [6:0]         shamt;
  logic [WORD_W-1:0]  va_sh;
  logic [AW-1:0]      ent_addr;
  logic [AW-1:0]      leaf_addr;
  logic [AW-1:0]      zero_addr;
  logic [AW-1:0]      rd_addr;
  logic [WORD_W-1:0]  pte;
  logic [WORD_W-1:0]  link_word;
  logic               mem_we;
  logic               mem_re;
  logic [AW-1:0]      mem_addr;
  logic [WORD_W-1:0]  mem_wdata;
  logic               map_ok;
  logic               alloc_ok;
  logic               read_ok;

  always_comb begin
    root_sl = slot_of(PPN_W'(root_q), start_q);
    free_sl = slot_of(PPN_W'(next_free_q), start_q);
    next_sl = slot_of(next_pg_q, start_q);
    if (({1'b0, next_free_q} + 45'd1) > {1'b0, end_q}) begin
      grab_st = ST_NO_MEM;
    end else if (!free_sl.ok) begin
      grab_st = ST_OUTSIDE;
    end else begin
      grab_st = ST_OK;
    end
  end

  // 9-bit table index of the current level
  assign shamt     = 7'd12 + 7'(level_q) * 7'd9;
  assign va_sh     = WORD_W'(va_q) >> shamt;
  assign ent_addr  = {slot_q, va_sh[8:0]};
  assign leaf_addr = {slot_q, va_q[20:12]};
  assign zero_addr = {zslot_q, zcnt_q};
  assign rd_addr   = AW'(widx_q);
  assign pte       = {10'd0, pa_q[PA_W-1:12], flags_q | 10'd1};
  assign link_word = {10'd0, next_pg_q[PAGE_W-1:0], 10'd1};

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = ent_addr;
    mem_wdata = '0;
    unique case (dp_cmd_i.op)
      DP_RD_ENT: begin
        mem_re = 1'b1;
      end
      DP_RD_WORD: begin
        mem_re   = 1'b1;
        mem_addr = rd_addr;
      end
      DP_ZERO: begin
        mem_we   = 1'b1;
        mem_addr = zero_addr;
      end
      DP_LINK: begin
        mem_we    = 1'b1;
        mem_wdata = link_word;
      end
      DP_LEAF: begin
        mem_we    = 1'b1;
        mem_addr  = leaf_addr;
        mem_wdata = pte;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= store_mem[mem_addr];
    end
  end

  // pool bounds and bump pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= RST_FREE_START;
      end_q       <= RST_FREE_END;
      next_free_q <= RST_FREE_START;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FREE_START: begin
          start_q     <= cfg_data_i;
          next_free_q <= cfg_data_i;
        end
        CFG_FREE_END: begin
          end_q <= cfg_data_i;
        end
      endcase
    end else if (dp_cmd_i.op == DP_GRAB) begin
      next_free_q <= next_free_q + 44'd1;
    end
  end

  assign map_ok   = (cmd_q == CMD_MAP) && (dp_cmd_i.fin_st == ST_OK);
  assign alloc_ok = (cmd_q == CMD_ALLOC) && (dp_cmd_i.fin_st == ST_OK);
  assign read_ok  = (cmd_q == CMD_READ) && (dp_cmd_i.fin_st == ST_OK);

  always_ff @(posedge clk_i) begin
    unique case (dp_cmd_i.op)
      DP_LOAD: begin
        cmd_q   <= cmd_i;
        root_q  <= root_page_i;
        va_q    <= virt_addr_i;
        pa_q    <= phys_addr_i;
        flags_q <= pte_flags_i;
        widx_q  <= word_index_i;
        added_q <= 2'd0;
        level_q <= LVW'(TABLE_LEVELS - 1);
      end
      DP_ROOT: begin
        slot_q <= root_sl.slot;
      end
      DP_TAKE_ENT: begin
        next_pg_q <= rdata_q[WORD_W-1:10];
      end
      DP_GRAB: begin
        next_pg_q <= PPN_W'(next_free_q);
        zslot_q   <= free_sl.slot;
        zcnt_q    <= 9'd0;
      end
      DP_ZERO: begin
        zcnt_q <= zcnt_q + 9'd1;
      end
      DP_LINK: begin
        added_q <= added_q + 2'd1;
      end
      DP_SLOT: begin
        slot_q  <= next_sl.slot;
        level_q <= level_q - LVW'(1);
      end
      default: begin
      end
    endcase
    if (dp_cmd_i.fin) begin
      status_q    <= dp_cmd_i.fin_st;
      new_page_q  <= alloc_ok ? next_pg_q[PAGE_W-1:0] : '0;
      leaf_q      <= map_ok ? WIDX_W'(leaf_addr) : '0;
      data_q      <= map_ok ? pte : (read_ok ? rdata_q : '0);
      added_out_q <= (cmd_q == CMD_MAP) ? added_q : 2'd0;
    end
  end

  always_comb begin
    dp_stat_o.cmd        = cmd_q;
    dp_stat_o.va_unal    = |va_q[11:0];
    dp_stat_o.pa_unal    = |pa_q[11:0];
    dp_stat_o.root_ok    = root_sl.ok;
    dp_stat_o.grab_st    = grab_st;
    dp_stat_o.widx_ok    = 32'(widx_q) < 32'(STORE_WORDS);
    dp_stat_o.ent_valid  = rdata_q[0];
    dp_stat_o.next_ok    = next_sl.ok;
    dp_stat_o.level_last = (level_q == LVW'(1));
    dp_stat_o.zero_last  = &zcnt_q;
  end

  assign status_o       = status_q;
  assign new_page_o     = new_page_q;
  assign leaf_word_o    = leaf_q;
  assign data_word_o    = data_q;
  assign tables_added_o = added_out_q;

endmodule

`default_nettype wire

@@ rtl/core/sv39ptm_ctrl.sv @@
// controller: sequences map, alloc and read commands over the datapath
// depends on sv39ptm_pkg and sv39_page_table_mapper_assert.svh
`default_nettype none
`include "sv39_page_table_mapper_assert.svh"

module sv39ptm_ctrl import sv39ptm_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  output logic          busy_o,
  output logic          done_o,
  output dp_cmd_t       dp_cmd_o,
  input  wire dp_stat_t dp_stat_i
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RD_ENT,
    S_CHK_ENT,
    S_ZERO,
    S_LINK,
    S_SLOT,
    S_LEAF,
    S_RD_WORD,
    S_RD_FIN
  } state_e;

  state_e  state_q, state_d;
  logic    done_q;
  dp_cmd_t cmd_d;

  always_comb begin
    state_d       = state_q;
    cmd_d.op      = DP_NOP;
    cmd_d.fin     = 1'b0;
    cmd_d.fin_st  = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_d.op = DP_LOAD;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (dp_stat_i.cmd)
          CMD_MAP: begin
            priority if (dp_stat_i.va_unal) begin
              cmd_d.fin    = 1'b1;
              cmd_d.fin_st = ST_VA_UNALIGNED;
            end else if (dp_stat_i.pa_unal) begin
              cmd_d.fin    = 1'b1;
              cmd_d.fin_st = ST_PA_UNALIGNED;
            end else if (!dp_stat_i.root_ok) begin
              cmd_d.fin    = 1'b1;
              cmd_d.fin_st = ST_OUTSIDE;
            end else begin
              cmd_d.op = DP_ROOT;
              state_d  = S_RD_ENT;
            end
          end
          CMD_ALLOC: begin
            if (dp_stat_i.grab_st != ST_OK) begin
              cmd_d.fin    = 1'b1;
              cmd_d.fin_st = dp_stat_i.grab_st;
            end else begin
              cmd_d.op = DP_GRAB;
              state_d  = S_ZERO;
            end
          end
          CMD_READ: begin
            if (!dp_stat_i.widx_ok) begin
              cmd_d.fin    = 1'b1;
              cmd_d.fin_st = ST_OUTSIDE;
            end else begin
              state_d = S_RD_WORD;
            end
          end
          default: begin
            cmd_d.fin = 1'b1;
          end
        endcase
      end
      S_RD_ENT: begin
        cmd_d.op = DP_RD_ENT;
        state_d  = S_CHK_ENT;
      end
      S_CHK_ENT: begin
        priority if (dp_stat_i.ent_valid) begin
          cmd_d.op = DP_TAKE_ENT;
          state_d  = S_SLOT;
        end else if (dp_stat_i.grab_st != ST_OK) begin
          cmd_d.fin    = 1'b1;
          cmd_d.fin_st = dp_stat_i.grab_st;
        end else begin
          cmd_d.op = DP_GRAB;
          state_d  = S_ZERO;
        end
      end
      S_ZERO: begin
        cmd_d.op = DP_ZERO;
        if (dp_stat_i.zero_last) begin
          if (dp_stat_i.cmd == CMD_ALLOC) begin
            cmd_d.fin = 1'b1;
          end else begin
            state_d = S_LINK;
          end
        end
      end
      S_LINK: begin
        cmd_d.op = DP_LINK;
        state_d  = S_SLOT;
      end
      S_SLOT: begin
        if (!dp_stat_i.next_ok) begin
          cmd_d.fin    = 1'b1;
          cmd_d.fin_st = ST_OUTSIDE;
        end else begin
          cmd_d.op = DP_SLOT;
          state_d  = dp_stat_i.level_last ? S_LEAF : S_RD_ENT;
        end
      end
      S_LEAF: begin
        cmd_d.op  = DP_LEAF;
        cmd_d.fin = 1'b1;
      end
      S_RD_WORD: begin
        cmd_d.op = DP_RD_WORD;
        state_d  = S_RD_FIN;
      end
      S_RD_FIN: begin
        cmd_d.fin = 1'b1;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (cmd_d.fin) begin
      state_d = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmd_d.fin;
    end
  end

  assign dp_cmd_o = cmd_d;
  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = done_q;

  `SV39PTM_ASSERT_NEXT(a_done_single, done_o, !done_o, "result strobe longer than one cycle")
  `SV39PTM_ASSERT_NEXT(a_start_decode, start_i && !busy_o, state_q == S_DECODE, "word not decoded")
  `SV39PTM_ASSERT_NEXT(a_zero_hold, (state_q == S_ZERO) && !dp_stat_i.zero_last, state_q == S_ZERO, "page clear cut short")
  `SV39PTM_ASSERT_IMPL(a_done_after_busy, done_o, $past(busy_o), "result without a command")

endmodule

`default_nettype wire

@@ rtl/core/sv39_page_table_mapper.sv @@
// top level of the sv39 page table mapper
// depends on sv39ptm_pkg, sv39ptm_ctrl and sv39ptm_dp
`default_nettype none

// A command word is taken when start_i is high while busy_o is low. Each command gives one
// result word, shown for a single cycle with done_o high; the receiver cannot stall it, so
// sample it when done_o is seen. All work goes through one single-port table store, one
// access per cycle, which sets the timing. A read decodes the command, reads the store word
// and then finishes. A map walks each upper level in the read, check and slot states and
// then writes the leaf; each table it allocates adds a clear of the new page, one word a
// cycle, and a link write. An alloc decodes and then clears its page. Alignment errors, a
// root outside the store, an exhausted alloc and an out of range read finish in the decode
// state. done_o follows the last busy cycle, and a new command may be given in that same
// cycle. The configuration channel is ready whenever the block is not busy. Store words
// never written by an alloc or map read back as undefined.
module sv39_page_table_mapper import sv39ptm_pkg::*; #(
  parameter int unsigned STORE_PAGES  = SPTM_STORE_PAGES,
  parameter int unsigned TABLE_LEVELS = SPTM_TABLE_LEVELS
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  output logic                      done_o,
  input  wire logic [1:0]           cmd_i,
  input  wire logic [PAGE_W-1:0]    root_page_i,
  input  wire logic [VA_W-1:0]      virt_addr_i,
  input  wire logic [PA_W-1:0]      phys_addr_i,
  input  wire logic [FLAGS_W-1:0]   pte_flags_i,
  input  wire logic [WIDX_W-1:0]    word_index_i,
  output logic [2:0]                status_o,
  output logic [PAGE_W-1:0]         new_page_o,
  output logic [WIDX_W-1:0]         leaf_word_o,
  output logic [WORD_W-1:0]         data_word_o,
  output logic [1:0]                tables_added_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [PAGE_W-1:0]    cfg_data_i
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;
  logic     cfg_we;

  assign cfg_ready_o = ~busy_o;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  sv39ptm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .busy_o    (busy_o),
    .done_o    (done_o),
    .dp_cmd_o  (dp_cmd),
    .dp_stat_i (dp_stat)
  );

  sv39ptm_dp #(
    .STORE_PAGES  (STORE_PAGES),
    .TABLE_LEVELS (TABLE_LEVELS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd_i),
    .root_page_i    (root_page_i),
    .virt_addr_i    (virt_addr_i),
    .phys_addr_i    (phys_addr_i),
    .pte_flags_i    (pte_flags_i),
    .word_index_i   (word_index_i),
    .dp_cmd_i       (dp_cmd),
    .dp_stat_o      (dp_stat),
    .status_o       (status_o),
    .new_page_o     (new_page_o),
    .leaf_word_o    (leaf_word_o),
    .data_word_o    (data_word_o),
    .tables_added_o (tables_added_o)
  );

endmodule

`default_nettype wire

@@ tb/sv39_page_table_mapper_tb.sv @@
// testbench for sv39_page_table_mapper: directed and random map, alloc and read commands
// a scoreboard class keeps its own table store and pool pointer and checks each result word
// depends on sv39ptm_pkg and the rtl of sv39_page_table_mapper

import sv39ptm_pkg::*;

localparam int unsigned STORE_WORDS = SPTM_STORE_PAGES * 512;

typedef struct packed {
  logic [1:0]         cmd;
  logic [PAGE_W-1:0]  root;
  logic [VA_W-1:0]    va;
  logic [PA_W-1:0]    pa;
  logic [FLAGS_W-1:0] flags;
  logic [WIDX_W-1:0]  widx;
} map_cmd_t;

typedef struct packed {
  logic [2:0]        status;
  logic [PAGE_W-1:0] new_page;
  logic [WIDX_W-1:0] leaf_word;
  logic [WORD_W-1:0] data_word;
  logic [1:0]        tables_added;
} map_resp_t;

class pte_scoreboard;
  logic [WORD_W-1:0] store_q [STORE_WORDS];
  bit                written [STORE_WORDS];
  bit                slot_zeroed [SPTM_STORE_PAGES];
  logic [PAGE_W-1:0] free_start = RST_FREE_START;
  logic [PAGE_W-1:0] free_end = RST_FREE_END;
  logic [PAGE_W-1:0] next_free = RST_FREE_START;
  logic [PAGE_W-1:0] table_pages [$];
  int unsigned       zeroed_slots [$];
  logic [WIDX_W-1:0] leaf_words [$];
  map_resp_t         due_results [$];
  int unsigned       errors;

  function int slot_of(logic [PPN_W-1:0] page);
    if (page < PPN_W'(free_start)) return -1;
    if (page - PPN_W'(free_start) >= SPTM_STORE_PAGES) return -1;
    return int'(page - PPN_W'(free_start));
  endfunction

  function logic [2:0] grab_page(output logic [PAGE_W-1:0] page);
    int s;
    page = '0;
    if ({1'b0, next_free} + 45'd1 > {1'b0, free_end}) return ST_NO_MEM;
    s = slot_of(PPN_W'(next_free));
    if (s < 0) return ST_OUTSIDE;
    for (int i = 0; i < 512; i++) begin
      store_q[s*512 + i] = '0;
      written[s*512 + i] = 1'b1;
    end
    if (!slot_zeroed[s]) begin
      slot_zeroed[s] = 1'b1;
      zeroed_slots.push_back(s);
    end
    page = next_free;
    table_pages.push_back(next_free);
    next_free = next_free + 1'b1;
    return ST_OK;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [PAGE_W-1:0] val);
    if (idx == CFG_FREE_START) begin
      free_start = val;
      next_free = val;
      table_pages.delete();
    end else begin
      free_end = val;
    end
  endfunction

  // true when a map walk would only read store words that hold known data
  function bit walk_is_defined(map_cmd_t c);
    int slot;
    int w;
    logic [WORD_W-1:0] ent;
    if (c.cmd != CMD_MAP || c.va[11:0] != 0 || c.pa[11:0] != 0) return 1'b1;
    slot = slot_of(PPN_W'(c.root));
    for (int lvl = SPTM_TABLE_LEVELS - 1; lvl > 0; lvl--) begin
      if (slot < 0) return 1'b1;
      w = slot*512 + 9'(c.va >> (12 + 9*lvl));
      if (!written[w]) return 1'b0;
      ent = store_q[w];
      if (!ent[0]) return 1'b1;
      slot = slot_of(ent[WORD_W-1:10]);
    end
    return 1'b1;
  endfunction

  function void note_command(map_cmd_t c);
    map_resp_t r;
    int slot;
    int w;
    logic [WORD_W-1:0] ent;
    logic [PAGE_W-1:0] fresh;
    logic [2:0] st;
    r = '0;
    case (c.cmd)
      CMD_MAP: begin
        if (c.va[11:0] != 0) begin
          r.status = ST_VA_UNALIGNED;
        end else if (c.pa[11:0] != 0) begin
          r.status = ST_PA_UNALIGNED;
        end else begin
          slot = slot_of(PPN_W'(c.root));
          if (slot < 0) r.status = ST_OUTSIDE;
          for (int lvl = SPTM_TABLE_LEVELS - 1; lvl > 0 && r.status == ST_OK; lvl--) begin
            w = slot*512 + 9'(c.va >> (12 + 9*lvl));
            ent = store_q[w];
            if (ent[0]) begin
              slot = slot_of(ent[WORD_W-1:10]);
            end else begin
              st = grab_page(fresh);
              if (st != ST_OK) begin
                r.status = st;
              end else begin
                store_q[w] = {10'd0, fresh, 10'd0} | 64'd1;
                written[w] = 1'b1;
                r.tables_added = r.tables_added + 2'd1;
                slot = slot_of(PPN_W'(fresh));
              end
            end
            if (r.status == ST_OK && slot < 0) r.status = ST_OUTSIDE;
          end
          if (r.status == ST_OK) begin
            w = slot*512 + 9'(c.va >> 12);
            store_q[w] = {10'd0, c.pa[PA_W-1:12], 10'd0} | 64'(c.flags) | 64'd1;
            written[w] = 1'b1;
            r.leaf_word = WIDX_W'(w);
            r.data_word = store_q[w];
            leaf_words.push_back(WIDX_W'(w));
            if (leaf_words.size() > 64) void'(leaf_words.pop_front());
          end
        end
      end
      CMD_ALLOC: begin
        r.status = grab_page(fresh);
        if (r.status == ST_OK) r.new_page = fresh;
      end
      CMD_READ: begin
        if (c.widx >= STORE_WORDS) r.status = ST_OUTSIDE;
        else r.data_word = store_q[c.widx];
      end
      default: ;
    endcase
    due_results.push_back(r);
  endfunction

  function void compare_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %h got %h", $time, name, want, got);
    end
  endfunction

  function void check_result(map_resp_t got);
    map_resp_t want;
    if (due_results.size() == 0) begin
      errors++;
      $display("%0t: result word with none expected, expected none got status %0d data %h",
               $time, got.status, got.data_word);
      return;
    end
    want = due_results.pop_front();
    compare_field("status", 64'(want.status), 64'(got.status));
    compare_field("new_page", 64'(want.new_page), 64'(got.new_page));
    compare_field("leaf_word", 64'(want.leaf_word), 64'(got.leaf_word));
    compare_field("data_word", want.data_word, got.data_word);
    compare_field("tables_added", 64'(want.tables_added), 64'(got.tables_added));
  endfunction
endclass

module sv39_page_table_mapper_tb;
  localparam logic [1:0]        CMD_UNUSED  = 2'd3;
  localparam int unsigned       CYCLE_LIMIT = 2_000_000;
  localparam int unsigned       PHASES      = 8;
  localparam logic [PAGE_W-1:0] PAGE_MAX    = '1;
  localparam logic [VA_W-1:0]   VA_TOP      = 39'h7F_FFFF_F000;
  localparam logic [PA_W-1:0]   PA_TOP      = 56'hFF_FFFF_FFFF_F000;
  localparam logic [PAGE_W-1:0] POOL_FIRST [PHASES] = '{
    44'd0, 44'd1000, 44'd5, PAGE_MAX - 44'd63, PAGE_MAX, 44'd0, 44'd200, 44'd0};
  localparam logic [PAGE_W-1:0] POOL_END [PHASES] = '{
    44'd64, 44'd1002, PAGE_MAX, PAGE_MAX, PAGE_MAX, 44'd0, 44'd100, 44'd64};
  localparam int unsigned PHASE_ITEMS [PHASES] = '{400, 150, 250, 250, 120, 120, 120, 200};

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start_i;
  logic                 busy_o;
  logic                 done_o;
  logic [1:0]           cmd_i;
  logic [PAGE_W-1:0]    root_page_i;
  logic [VA_W-1:0]      virt_addr_i;
  logic [PA_W-1:0]      phys_addr_i;
  logic [FLAGS_W-1:0]   pte_flags_i;
  logic [WIDX_W-1:0]    word_index_i;
  logic [2:0]           status_o;
  logic [PAGE_W-1:0]    new_page_o;
  logic [WIDX_W-1:0]    leaf_word_o;
  logic [WORD_W-1:0]    data_word_o;
  logic [1:0]           tables_added_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [PAGE_W-1:0]    cfg_data_i;

  pte_scoreboard pte_sb = new();
  int unsigned   cycle_cnt;
  bit            no_gaps;

  sv39_page_table_mapper u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .done_o         (done_o),
    .cmd_i          (cmd_i),
    .root_page_i    (root_page_i),
    .virt_addr_i    (virt_addr_i),
    .phys_addr_i    (phys_addr_i),
    .pte_flags_i    (pte_flags_i),
    .word_index_i   (word_index_i),
    .status_o       (status_o),
    .new_page_o     (new_page_o),
    .leaf_word_o    (leaf_word_o),
    .data_word_o    (data_word_o),
    .tables_added_o (tables_added_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    wait (cycle_cnt == CYCLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      pte_sb.check_result(map_resp_t'{status_o, new_page_o, leaf_word_o, data_word_o,
                                      tables_added_o});
    end
  end

  function automatic map_cmd_t make_command(logic [1:0] cmd, logic [PAGE_W-1:0] root,
                                            logic [VA_W-1:0] va, logic [PA_W-1:0] pa,
                                            logic [FLAGS_W-1:0] flags,
                                            logic [WIDX_W-1:0] widx);
    map_cmd_t c;
    c = '{cmd, root, va, pa, flags, widx};
    return c;
  endfunction

  // upper table indexes come from a small set so that links get reused
  function automatic logic [8:0] level_index();
    case ($urandom_range(0, 3))
      0:       return 9'd0;
      1:       return 9'd511;
      default: return 9'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic map_cmd_t random_command();
    map_cmd_t    c;
    int unsigned pick;
    c = make_command(CMD_MAP, PAGE_W'({$urandom, $urandom}), VA_W'({$urandom, $urandom}),
                     PA_W'({$urandom, $urandom}), FLAGS_W'($urandom), WIDX_W'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      c.cmd = CMD_ALLOC;
    end else if (pick < 8) begin
      c.cmd = CMD_UNUSED;
    end else if (pick < 30) begin
      c.cmd = CMD_READ;
      if (pte_sb.leaf_words.size() != 0 && $urandom_range(0, 1)) begin
        c.widx = pte_sb.leaf_words[$urandom_range(0, pte_sb.leaf_words.size() - 1)];
      end else if (pte_sb.zeroed_slots.size() != 0) begin
        c.widx = WIDX_W'(pte_sb.zeroed_slots[$urandom_range(0, pte_sb.zeroed_slots.size() - 1)]
                         * 512 + $urandom_range(0, 511));
      end else begin
        c.cmd = CMD_ALLOC;
      end
    end else if (pick < 38) begin
      if ($urandom_range(0, 1)) begin
        c.va[11:0] = 12'($urandom_range(1, 4095));
      end else begin
        c.va[11:0] = '0;
        c.pa[11:0] = 12'($urandom_range(1, 4095));
      end
    end else begin
      c.va = {level_index(), level_index(), 9'($urandom), 12'd0};
      c.pa[11:0] = '0;
      if (pick < 93 && pte_sb.table_pages.size() != 0) begin
        c.root = pte_sb.table_pages[$urandom_range(0, pte_sb.table_pages.size() - 1)];
      end else if (pick < 96) begin
        c.root = pte_sb.free_start + $urandom_range(0, 70);
      end
      // a walk through never written words turns into an unaligned map
      if (!pte_sb.walk_is_defined(c)) c.va[11:0] = 12'h800;
    end
    return c;
  endfunction

  task automatic send(input map_cmd_t c);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i      <= 1'b1;
    cmd_i        <= c.cmd;
    root_page_i  <= c.root;
    virt_addr_i  <= c.va;
    phys_addr_i  <= c.pa;
    pte_flags_i  <= c.flags;
    word_index_i <= c.widx;
    do @(posedge clk_i); while (busy_o);
    pte_sb.note_command(c);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (pte_sb.due_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_pool(input logic [PAGE_W-1:0] pool_start,
                          input logic [PAGE_W-1:0] pool_end);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_FREE_START;
    cfg_data_i  <= pool_start;
    do @(posedge clk_i); while (!cfg_ready_o);
    pte_sb.write_reg(CFG_FREE_START, pool_start);
    cfg_index_i <= CFG_FREE_END;
    cfg_data_i  <= pool_end;
    do @(posedge clk_i); while (!cfg_ready_o);
    pte_sb.write_reg(CFG_FREE_END, pool_end);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    rst_ni       <= 1'b0;
    start_i      <= 1'b0;
    cmd_i        <= '0;
    root_page_i  <= '0;
    virt_addr_i  <= '0;
    phys_addr_i  <= '0;
    pte_flags_i  <= '0;
    word_index_i <= '0;
    cfg_valid_i  <= 1'b0;
    cfg_index_i  <= '0;
    cfg_data_i   <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: fresh tables, reused links, alignment and range errors, reads
    send(make_command(CMD_ALLOC, '0, '0, '0, '0, '0));
    send(make_command(CMD_MAP, 44'd0, '0, '0, '0, '0));
    send(make_command(CMD_MAP, 44'd0, VA_TOP, PA_TOP, '1, '0));
    send(make_command(CMD_MAP, 44'd0, 39'h1000, 56'h1234_5000, 10'h0CF, '0));
    send(make_command(CMD_MAP, 44'd0, 39'h1, '0, '0, '0));
    send(make_command(CMD_MAP, 44'd0, '1, '1, '0, '0));
    send(make_command(CMD_MAP, 44'd0, '0, '1, '0, '0));
    send(make_command(CMD_MAP, 44'd64, VA_TOP, '0, '0, '0));
    send(make_command(CMD_MAP, PAGE_MAX, '0, '0, '0, '0));
    send(make_command(CMD_MAP, 44'd4, VA_TOP, '0, '0, '0));
    send(make_command(CMD_READ, '0, '0, '0, '0, 15'd1024));
    send(make_command(CMD_READ, '0, '0, '0, '0, 15'd2559));
    send(make_command(CMD_READ, '0, '0, '0, '0, 15'd1025));
    send(make_command(CMD_READ, '0, '0, '0, '0, 15'd0));
    send(make_command(CMD_READ, '0, '0, '0, '0, 15'd511));
    send(make_command(CMD_UNUSED, '1, '1, '1, '1, '1));
    send(make_command(CMD_UNUSED, '0, '0, '0, '0, '0));
    send(make_command(CMD_ALLOC, '1, '1, '1, '1, '1));
    send(make_command(CMD_MAP, 44'd5, 39'h40_0000_0000, 56'h80_0000_0000_0000, 10'h155, '0));

    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        drain();
        set_pool(POOL_FIRST[p], POOL_END[p]);
      end
      if (p == 1) begin
        // pool of two pages: the second table of the walk runs out
        send(make_command(CMD_ALLOC, '0, '0, '0, '0, '0));
        send(make_command(CMD_MAP, POOL_FIRST[1], '0, '0, '0, '0));
      end
      if (p == 2) begin
        // fill the store, then a walk whose second table lands outside it
        repeat (63) send(make_command(CMD_ALLOC, '0, '0, '0, '0, '0));
        send(make_command(CMD_MAP, POOL_FIRST[2], VA_TOP, '0, '0, '0));
        send(make_command(CMD_ALLOC, '0, '0, '0, '0, '0));
      end
      repeat (PHASE_ITEMS[p]) begin
        if ($urandom_range(0, 39) == 0) no_gaps = !no_gaps;
        send(random_command());
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (pte_sb.errors == 0 && pte_sb.due_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/sv39ptm_pkg.sv
rtl/core/sv39ptm_dp.sv
rtl/core/sv39ptm_ctrl.sv
rtl/core/sv39_page_table_mapper.sv
tb/sv39_page_table_mapper_tb.sv
